// ===== rtl/salr_pkg.sv =====
// ----------------------------------------------------------------------------
// salr_pkg
// Shared widths, register codes and sequencer states of the stroke
// arc-length resampler.
// ----------------------------------------------------------------------------
package salr_pkg;

    localparam int COORD_W        = 16;
    localparam int TGT_W          = 7;
    localparam int MAX_POINTS     = 256;
    localparam int PT_AW          = $clog2(MAX_POINTS);
    localparam int CNT_W          = PT_AW + 1;
    localparam int LEN_W          = 24;
    localparam int TOT_W          = 32;
    localparam int MAX_OUT_POINTS = 64;
    localparam int MWS_W          = 8;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    // register index codes (paddr[2])
    localparam logic [0:0] REG_MIN_WEIGHT_SUM = 1'b0;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LD_STORE,
        ST_LD_SQY,
        ST_LD_SQSUM,
        ST_LD_ROOT,
        ST_LD_RND,
        ST_LD_NEXT,
        ST_EM_START,
        ST_EM_PUSH,
        ST_EM_FINISH,
        ST_WK_CHECK,
        ST_WK_RD,
        ST_WK_ADD,
        ST_SG_RD1,
        ST_SG_RD2,
        ST_SG_W,
        ST_SG_CL,
        ST_BL_WA,
        ST_BL_M1,
        ST_BL_M2,
        ST_BL_SUM,
        ST_BL_ABS,
        ST_BL_PREP,
        ST_BL_DIV,
        ST_BL_DONE
    } state_t;

endpackage

// ===== rtl/salr_pnt_if.sv =====
// ----------------------------------------------------------------------------
// salr_pnt_if
// Stroke point channel: one word per pen point.
// ----------------------------------------------------------------------------
interface salr_pnt_if
    import salr_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] x_in;
    logic signed [COORD_W-1:0] y_in;
    logic                      last_point;
    logic [TGT_W-1:0]          target_points;

    modport source (output valid, x_in, y_in, last_point, target_points, input ready);
    modport sink   (input valid, x_in, y_in, last_point, target_points, output ready);
endinterface

// ===== rtl/salr_smp_if.sv =====
// ----------------------------------------------------------------------------
// salr_smp_if
// Resampled point channel: one word per emitted point.
// ----------------------------------------------------------------------------
interface salr_smp_if
    import salr_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] x_out;
    logic signed [COORD_W-1:0] y_out;
    logic                      last_out;

    modport source (output valid, x_out, y_out, last_out, input ready);
    modport sink   (input valid, x_out, y_out, last_out, output ready);
endinterface

// ===== rtl/stroke_arc_length_resampler.sv =====
// ----------------------------------------------------------------------------
// stroke_arc_length_resampler
// Loads a pen stroke, keeps points and segment lengths, and emits points
// spaced equally along the arc length using one shared multiplier and one
// shared compare-subtract unit under a sequencer.
// ----------------------------------------------------------------------------
// Load: a stored point takes two squares on the multiplier, 21 root steps on
//   the compare-subtract unit, rounding and bookkeeping; the first point of a
//   stroke is only stored.
// Emit: an interpolated inner point walks the segments one by one, then runs
//   two 17-step divisions on the same unit.
// Input is not ready while a point or an emission is in progress.
// Reset (rst_n low, asynchronous) clears point count, total length, the
//   register and the output; point stores need no clearing.
// ----------------------------------------------------------------------------
module stroke_arc_length_resampler
    import salr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    salr_pnt_if.sink           pnt,
    salr_smp_if.source         smp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // stores
    logic [COORD_W-1:0] mem_x [MAX_POINTS];
    logic [COORD_W-1:0] mem_y [MAX_POINTS];
    logic [LEN_W-1:0]   mem_len [MAX_POINTS];

    state_t state_reg, state_next;

    // control
    logic [CNT_W-1:0] cnt_reg;
    logic [TOT_W-1:0] total_reg;
    logic [MWS_W-1:0] mws_reg;
    logic             out_valid_reg;

    // payload
    logic signed [COORD_W-1:0] in_x_reg, in_y_reg, prev_x_reg, prev_y_reg;
    logic signed [COORD_W-1:0] first_x_reg, first_y_reg;
    logic signed [COORD_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [COORD_W-1:0] res_x_reg, res_y_reg;
    logic signed [COORD_W-1:0] out_x_reg, out_y_reg;
    logic                      out_last_reg, res_last_reg;
    logic                      in_last_reg, sel_reg, neg_reg;
    logic [TGT_W-1:0]          in_tgt_reg, tgt_reg, pushed_reg;
    logic [TGT_W-1:0]          scale_reg;
    logic [PT_AW-1:0]          s_reg;
    logic [33:0]               measured_reg, balance_reg, m2_reg;
    logic [29:0]               w_reg, wa_reg;
    logic [LEN_W-1:0]          lenw_reg;
    logic signed [49:0]        mul_reg, num_reg;
    logic [33:0]               sq_reg;
    logic [41:0]               v_reg;
    logic [46:0]               rem_reg, dsh_reg;
    logic [45:0]               mag_reg;
    logic [20:0]               acc_reg;
    logic [4:0]                step_reg;
    logic [COORD_W-1:0]        x_q_reg, y_q_reg;
    logic [LEN_W-1:0]          len_q_reg;

    // combinational
    logic               slot_free, push_fire, walk_more, cfg_wr;
    logic [CNT_W-1:0]   nseg;
    logic [TGT_W:0]     pushed_new;
    logic [TGT_W-1:0]   tgt_clamp;
    logic [PT_AW-1:0]   pt_raddr, len_raddr;
    logic signed [31:0] mul_a;
    logic signed [17:0] mul_b;
    logic [46:0]        sub_a, sub_b;
    logic [47:0]        sub_diff;
    logic               sub_ge;
    logic signed [16:0] dx, dy;
    logic [32:0]        tot_sum;
    logic [21:0]        len_rnd;
    logic [34:0]        m2_diff;
    logic [16:0]        q_neg;
    logic [COORD_W-1:0] q_val;

    assign nseg       = cnt_reg - CNT_W'(1);
    assign slot_free  = !out_valid_reg || smp.ready;
    assign push_fire  = (state_reg == ST_EM_PUSH) && slot_free;
    assign walk_more  = (measured_reg < {2'b0, total_reg}) && ({1'b0, s_reg} < nseg);
    assign pushed_new = {1'b0, pushed_reg} + (TGT_W+1)'(1);
    assign cfg_wr     = psel && penable && pwrite;
    assign dx         = 17'(in_x_reg) - 17'(prev_x_reg);
    assign dy         = 17'(in_y_reg) - 17'(prev_y_reg);
    assign tot_sum    = {1'b0, total_reg} + 33'(len_rnd);
    assign len_rnd    = {1'b0, acc_reg} + ((22'(rem_reg[21:0]) > {1'b0, acc_reg}) ? 22'd1 : 22'd0);
    assign m2_diff    = {1'b0, measured_reg} - {3'b0, total_reg};
    assign q_neg      = 17'd0 - acc_reg[16:0];
    assign q_val      = neg_reg ? q_neg[15:0] : acc_reg[15:0];

    // clamp target to 1..MAX_OUT_POINTS
    always_comb
    begin
        if (in_tgt_reg == '0)
        begin
            tgt_clamp = TGT_W'(1);
        end
        else if (in_tgt_reg > TGT_W'(MAX_OUT_POINTS))
        begin
            tgt_clamp = TGT_W'(MAX_OUT_POINTS);
        end
        else
        begin
            tgt_clamp = in_tgt_reg;
        end
    end

    // pick read addresses
    always_comb
    begin
        pt_raddr  = s_reg;
        len_raddr = s_reg;
        if (state_reg == ST_SG_RD1)
        begin
            pt_raddr = s_reg - PT_AW'(1);
        end
        if (state_reg == ST_WK_CHECK && !walk_more)
        begin
            len_raddr = s_reg - PT_AW'(1);
        end
    end

    // steer shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_LD_STORE:
            begin
                mul_a = 32'(dx);
                mul_b = 18'(dx);
            end
            ST_LD_SQY:
            begin
                mul_a = 32'(dy);
                mul_b = 18'(dy);
            end
            ST_WK_RD:
            begin
                mul_a = {8'b0, len_q_reg};
                mul_b = {11'b0, scale_reg};
            end
            ST_SG_RD2:
            begin
                mul_a = {8'b0, lenw_reg};
                mul_b = {11'b0, scale_reg};
            end
            ST_BL_M1:
            begin
                mul_a = {2'b0, wa_reg};
                mul_b = sel_reg ? 18'(ay_reg) : 18'(ax_reg);
            end
            ST_BL_M2:
            begin
                mul_a = {2'b0, m2_reg[29:0]};
                mul_b = sel_reg ? 18'(by_reg) : 18'(bx_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // steer shared compare-subtract: root step or divide step
    always_comb
    begin
        if (state_reg == ST_LD_ROOT)
        begin
            sub_a = {23'b0, rem_reg[21:0], v_reg[41:40]};
            sub_b = {24'b0, acc_reg, 2'b01};
        end
        else
        begin
            sub_a = rem_reg;
            sub_b = dsh_reg;
        end
        sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
        sub_ge   = !sub_diff[47];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pnt.valid)
                begin
                    if (cnt_reg < CNT_W'(MAX_POINTS))
                    begin
                        state_next = ST_LD_STORE;
                    end
                    else if (pnt.last_point)
                    begin
                        state_next = ST_EM_START;
                    end
                end
            end
            ST_LD_STORE: state_next = (cnt_reg == '0) ? ST_LD_NEXT : ST_LD_SQY;
            ST_LD_SQY:   state_next = ST_LD_SQSUM;
            ST_LD_SQSUM: state_next = ST_LD_ROOT;
            ST_LD_ROOT:  state_next = (step_reg == '0) ? ST_LD_RND : ST_LD_ROOT;
            ST_LD_RND:   state_next = ST_LD_NEXT;
            ST_LD_NEXT:  state_next = in_last_reg ? ST_EM_START : ST_IDLE;
            ST_EM_START: state_next = ST_EM_PUSH;
            ST_EM_PUSH:
            begin
                if (slot_free)
                begin
                    if (res_last_reg)
                    begin
                        state_next = ST_EM_FINISH;
                    end
                    else if (cnt_reg != CNT_W'(1)
                             && pushed_new + (TGT_W+1)'(1) < {1'b0, tgt_reg})
                    begin
                        state_next = ST_WK_CHECK;
                    end
                end
            end
            ST_EM_FINISH: state_next = ST_IDLE;
            ST_WK_CHECK:
            begin
                if (walk_more)
                begin
                    state_next = ST_WK_RD;
                end
                else if (s_reg == '0)
                begin
                    state_next = ST_EM_PUSH;
                end
                else
                begin
                    state_next = ST_SG_RD1;
                end
            end
            ST_WK_RD:  state_next = ST_WK_ADD;
            ST_WK_ADD: state_next = ST_WK_CHECK;
            ST_SG_RD1: state_next = ST_SG_RD2;
            ST_SG_RD2: state_next = ST_SG_W;
            ST_SG_W:   state_next = ST_SG_CL;
            ST_SG_CL:
            begin
                state_next = (lenw_reg <= LEN_W'(mws_reg)) ? ST_EM_PUSH : ST_BL_WA;
            end
            ST_BL_WA:   state_next = ST_BL_M1;
            ST_BL_M1:   state_next = ST_BL_M2;
            ST_BL_M2:   state_next = ST_BL_SUM;
            ST_BL_SUM:  state_next = ST_BL_ABS;
            ST_BL_ABS:  state_next = ST_BL_PREP;
            ST_BL_PREP: state_next = ST_BL_DIV;
            ST_BL_DIV:  state_next = (step_reg == '0) ? ST_BL_DONE : ST_BL_DIV;
            ST_BL_DONE: state_next = sel_reg ? ST_EM_PUSH : ST_BL_M1;
            default:    state_next = ST_IDLE;
        endcase
    end

    // port outputs
    always_comb
    begin
        pnt.ready    = (state_reg == ST_IDLE);
        smp.valid    = out_valid_reg;
        smp.x_out    = out_x_reg;
        smp.y_out    = out_y_reg;
        smp.last_out = out_last_reg;
        pready       = 1'b1;
        prdata       = (paddr[2] == REG_MIN_WEIGHT_SUM) ? PDATA_W'(mws_reg) : '0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            total_reg     <= '0;
            mws_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr && paddr[2] == REG_MIN_WEIGHT_SUM)
            begin
                mws_reg <= pwdata[MWS_W-1:0];
            end
            // advance point count and saturate total length
            if (state_reg == ST_LD_NEXT)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (state_reg == ST_LD_RND)
            begin
                total_reg <= tot_sum[32] ? '1 : tot_sum[31:0];
            end
            if (state_reg == ST_EM_FINISH)
            begin
                cnt_reg   <= '0;
                total_reg <= '0;
            end
            // hold or drop output word
            if (push_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (smp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // stores: write one port, registered read
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LD_STORE)
        begin
            mem_x[cnt_reg[PT_AW-1:0]] <= in_x_reg;
            mem_y[cnt_reg[PT_AW-1:0]] <= in_y_reg;
        end
        if (state_reg == ST_LD_RND)
        begin
            mem_len[nseg[PT_AW-1:0]] <= LEN_W'(len_rnd);
        end
        x_q_reg   <= mem_x[pt_raddr];
        y_q_reg   <= mem_y[pt_raddr];
        len_q_reg <= mem_len[len_raddr];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        mul_reg <= 50'(mul_a) * 50'(mul_b);
        if (push_fire)
        begin
            out_x_reg    <= res_x_reg;
            out_y_reg    <= res_y_reg;
            out_last_reg <= res_last_reg;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                in_x_reg    <= pnt.x_in;
                in_y_reg    <= pnt.y_in;
                in_last_reg <= pnt.last_point;
                in_tgt_reg  <= pnt.target_points;
            end
            ST_LD_STORE:
            begin
                if (cnt_reg == '0)
                begin
                    first_x_reg <= in_x_reg;
                    first_y_reg <= in_y_reg;
                end
            end
            ST_LD_SQY:
            begin
                sq_reg <= mul_reg[33:0];
            end
            ST_LD_SQSUM:
            begin
                v_reg    <= {sq_reg + mul_reg[33:0], 8'b0};
                acc_reg  <= '0;
                rem_reg  <= '0;
                step_reg <= 5'd20;
            end
            ST_LD_ROOT:
            begin
                rem_reg  <= sub_ge ? sub_diff[46:0] : sub_a;
                acc_reg  <= {acc_reg[19:0], sub_ge};
                v_reg    <= {v_reg[39:0], 2'b00};
                step_reg <= step_reg - 5'd1;
            end
            ST_LD_NEXT:
            begin
                prev_x_reg <= in_x_reg;
                prev_y_reg <= in_y_reg;
            end
            ST_EM_START:
            begin
                tgt_reg      <= tgt_clamp;
                scale_reg    <= (tgt_clamp > TGT_W'(1)) ? tgt_clamp - TGT_W'(1) : TGT_W'(1);
                pushed_reg   <= '0;
                s_reg        <= '0;
                balance_reg  <= '0;
                res_x_reg    <= first_x_reg;
                res_y_reg    <= first_y_reg;
                res_last_reg <= (cnt_reg == CNT_W'(1)) && (tgt_clamp == TGT_W'(1));
            end
            ST_EM_PUSH:
            begin
                if (slot_free)
                begin
                    pushed_reg   <= pushed_new[TGT_W-1:0];
                    measured_reg <= balance_reg;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        res_x_reg    <= first_x_reg;
                        res_y_reg    <= first_y_reg;
                        res_last_reg <= (pushed_new + (TGT_W+1)'(1) == {1'b0, tgt_reg});
                    end
                    else if (pushed_new + (TGT_W+1)'(1) >= {1'b0, tgt_reg})
                    begin
                        res_x_reg    <= prev_x_reg;
                        res_y_reg    <= prev_y_reg;
                        res_last_reg <= 1'b1;
                    end
                end
            end
            ST_WK_CHECK:
            begin
                if (!walk_more && s_reg == '0)
                begin
                    res_x_reg    <= first_x_reg;
                    res_y_reg    <= first_y_reg;
                    res_last_reg <= 1'b0;
                    balance_reg  <= '0;
                end
            end
            ST_WK_ADD:
            begin
                measured_reg <= measured_reg + mul_reg[33:0];
                s_reg        <= s_reg + PT_AW'(1);
            end
            ST_SG_RD1:
            begin
                ax_reg   <= x_q_reg;
                ay_reg   <= y_q_reg;
                lenw_reg <= len_q_reg;
            end
            ST_SG_RD2:
            begin
                bx_reg <= x_q_reg;
                by_reg <= y_q_reg;
            end
            ST_SG_W:
            begin
                w_reg  <= mul_reg[29:0];
                m2_reg <= m2_diff[34] ? '0 : m2_diff[33:0];
            end
            ST_SG_CL:
            begin
                if (m2_reg > {4'b0, w_reg})
                begin
                    m2_reg      <= {4'b0, w_reg};
                    balance_reg <= {4'b0, w_reg};
                end
                else
                begin
                    balance_reg <= m2_reg;
                end
                res_x_reg    <= ax_reg;
                res_y_reg    <= ay_reg;
                res_last_reg <= 1'b0;
                sel_reg      <= 1'b0;
            end
            ST_BL_WA:
            begin
                wa_reg <= w_reg - m2_reg[29:0];
            end
            ST_BL_M2:
            begin
                num_reg <= mul_reg;
            end
            ST_BL_SUM:
            begin
                num_reg <= num_reg + mul_reg;
            end
            ST_BL_ABS:
            begin
                neg_reg <= num_reg[49];
                mag_reg <= num_reg[49] ? 46'(-num_reg) : num_reg[45:0];
            end
            ST_BL_PREP:
            begin
                rem_reg  <= {mag_reg, 1'b0} + 47'(w_reg);
                dsh_reg  <= {w_reg, 17'b0};
                acc_reg  <= '0;
                step_reg <= 5'd16;
            end
            ST_BL_DIV:
            begin
                rem_reg  <= sub_ge ? sub_diff[46:0] : sub_a;
                acc_reg  <= {acc_reg[19:0], sub_ge};
                dsh_reg  <= {1'b0, dsh_reg[46:1]};
                step_reg <= step_reg - 5'd1;
            end
            ST_BL_DONE:
            begin
                if (sel_reg)
                begin
                    res_y_reg <= q_val;
                end
                else
                begin
                    res_x_reg <= q_val;
                end
                sel_reg <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WK_ADD) |-> ({1'b0, s_reg} < nseg))
        else $error("segment walk past last segment");

    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BL_DONE) |-> (acc_reg[16:0] <= 17'd32768))
        else $error("blend quotient out of range");

    a_push_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EM_PUSH))
        else $error("output word without push");

endmodule

// ===== test/stroke_arc_length_resampler_tb.sv =====
// ----------------------------------------------------------------------------
// stroke_arc_length_resampler_tb
// Loads pen strokes into the resampler and checks every resampled point
// against an in-bench arc-length predictor. The run starts with a directed
// table of short strokes, then sends random strokes under several
// min_weight_sum settings. Both channels idle at random, and the receiver
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
module stroke_arc_length_resampler_tb;
    import salr_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int WDOG_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 300;
    localparam logic [PADDR_W-1:0] ADDR_MIN_WEIGHT = {REG_MIN_WEIGHT_SUM, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED   = 3'(4);

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
    } sample_t;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
        logic [TGT_W-1:0]          tgt;
        bit                        known;   // every result of this point is (kx, ky)
        logic signed [COORD_W-1:0] kx;
        logic signed [COORD_W-1:0] ky;
    } point_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel, penable, pwrite, pready;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata, prdata;

    salr_pnt_if pnt ();
    salr_smp_if smp ();

    stroke_arc_length_resampler uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pnt     (pnt.sink),
        .smp     (smp.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic signed [COORD_W-1:0] stroke_x [MAX_POINTS];
    logic signed [COORD_W-1:0] stroke_y [MAX_POINTS];
    logic [LEN_W-1:0]          seg_len  [MAX_POINTS];
    int unsigned               stored_pts = 0;
    logic [TOT_W-1:0]          arc_total = '0;
    logic [MWS_W-1:0]          weight_floor;

    point_t  point_q  [$];
    sample_t sample_q [$];
    bit      calm;
    bit      hold_req = 0;
    int      errors = 0;
    int      strokes_sent = 0;
    int      samples_seen = 0;
    int      quiet_cycles = 0;

    // known-result tags, kept in step with accepted points
    point_t tagged_known [$];

    // rounded integer square root
    function automatic longint unsigned round_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        if (v > r) r++;
        return r;
    endfunction

    // weighted mean of two coordinates, ties away from zero
    function automatic logic signed [COORD_W-1:0] mix(longint unsigned wa, int a,
                                                      longint unsigned wb, int b);
        longint          num;
        longint unsigned den, mag, q;
        num = longint'(wa) * a + longint'(wb) * b;
        den = wa + wb;
        mag = (num < 0) ? longint'(-num) : num;
        q = (2 * mag + den) / (2 * den);
        return (num < 0) ? COORD_W'(-longint'(q)) : COORD_W'(q);
    endfunction

    function automatic void push_sample(int i, bit fin);
        sample_q.insert(sample_q.size(), '{stroke_x[i], stroke_y[i], fin});
    endfunction

    // emit the resampled stroke into the expected queue
    function automatic void resample(int unsigned tgt);
        int unsigned     n, nseg, s, k;
        longint unsigned scale, spacing, walked, carry, w, m2;
        n = stored_pts;
        s = 0;
        carry = 0;
        if (tgt == 0) tgt = 1;
        if (tgt > MAX_OUT_POINTS) tgt = MAX_OUT_POINTS;
        if (n == 1)
        begin
            for (k = 0; k < tgt; k++) push_sample(0, k + 1 == tgt);
            return;
        end
        nseg = n - 1;
        scale = (tgt > 1) ? tgt - 1 : 1;
        spacing = arc_total;
        push_sample(0, 0);
        for (k = 1; k + 1 < tgt; k++)
        begin
            walked = carry;
            while (walked < spacing && s < nseg)
            begin
                walked += seg_len[s] * scale;
                s++;
            end
            if (s == 0)
            begin
                push_sample(0, 0);
                carry = 0;
            end
            else
            begin
                w = seg_len[s-1] * scale;
                m2 = (walked >= spacing) ? walked - spacing : 0;
                if (m2 > w) m2 = w;
                if (seg_len[s-1] <= weight_floor)
                    push_sample(s, 0);
                else
                    sample_q.insert(sample_q.size(),
                                    '{mix(w - m2, stroke_x[s], m2, stroke_x[s-1]),
                                      mix(w - m2, stroke_y[s], m2, stroke_y[s-1]), 1'b0});
                carry = m2;
            end
        end
        push_sample(n - 1, 1);
    endfunction

    // load one point, return the number of samples it caused
    function automatic int load_point(point_t p);
        int              i, base_size;
        longint          dx, dy;
        longint unsigned sq, t;
        logic [LEN_W-1:0] len;
        base_size = sample_q.size();
        if (stored_pts < MAX_POINTS)
        begin
            i = stored_pts;
            if (i > 0)
            begin
                dx = longint'(p.x) - stroke_x[i-1];
                dy = longint'(p.y) - stroke_y[i-1];
                sq = dx * dx + dy * dy;
                len = LEN_W'(round_sqrt(sq << 8));
                seg_len[i-1] = len;
                t = longint'(arc_total) + len;
                arc_total = (t > 64'hFFFF_FFFF) ? '1 : TOT_W'(t);
            end
            stroke_x[i] = p.x;
            stroke_y[i] = p.y;
            stored_pts = i + 1;
        end
        if (p.last)
        begin
            resample(p.tgt);
            stored_pts = 0;
            arc_total = 0;
        end
        return sample_q.size() - base_size;
    endfunction

    // clock
    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    // sender: advance to the next word once the current one is taken
    initial
    begin
        point_t p;
        pnt.valid <= 0;
        pnt.x_in <= '0;
        pnt.y_in <= '0;
        pnt.last_point <= 0;
        pnt.target_points <= '0;
        forever
        begin
            @(posedge clk);
            if (!rst_n) continue;
            if (!pnt.valid || pnt.ready)
            begin
                if (point_q.size() > 0 && (calm || $urandom_range(99) >= 24))
                begin
                    p = point_q.pop_front();
                    pnt.valid <= 1;
                    pnt.x_in <= p.x;
                    pnt.y_in <= p.y;
                    pnt.last_point <= p.last;
                    pnt.target_points <= p.tgt;
                end
                else
                    pnt.valid <= 0;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off once a word is waiting
    initial
    begin
        bit hold_done;
        hold_done = 0;
        smp.ready <= 0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done && smp.valid)
            begin
                hold_done = 1;
                smp.ready <= 0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            smp.ready <= rst_n && (calm || $urandom_range(99) >= 24);
        end
    end

    // monitor: predict on each accepted point, check each accepted sample
    always @(posedge clk)
    begin
        point_t  p;
        sample_t got, want;
        int      cnt;
        if (rst_n && pnt.valid && pnt.ready)
        begin
            p = '{pnt.x_in, pnt.y_in, pnt.last_point, pnt.target_points, 0, 0, 0};
            cnt = load_point(p);
            if (p.last) strokes_sent++;
            // a flagged table row carries its own expected point
            if (tagged_known.size() > 0 && tagged_known[0].known)
            begin
                for (int j = sample_q.size() - cnt; j < sample_q.size(); j++)
                    if (sample_q[j].x !== tagged_known[0].kx ||
                        sample_q[j].y !== tagged_known[0].ky)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("table row: expected (%0d,%0d) predicted (%0d,%0d)",
                                     tagged_known[0].kx, tagged_known[0].ky,
                                     sample_q[j].x, sample_q[j].y);
                    end
            end
            if (tagged_known.size() > 0) void'(tagged_known.pop_front());
        end
        if (rst_n && smp.valid && smp.ready)
        begin
            got = '{smp.x_out, smp.y_out, smp.last_out};
            samples_seen++;
            if (sample_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected sample x=%0d y=%0d last=%0d", got.x, got.y, got.last);
            end
            else
            begin
                want = sample_q.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("sample %0d: expected x=%0d y=%0d last=%0d, got x=%0d y=%0d last=%0d",
                                 samples_seen, want.x, want.y, want.last,
                                 got.x, got.y, got.last);
                end
            end
        end
    end

    // watchdog: count cycles with no word moving on any port
    always @(posedge clk)
    begin
        if ((pnt.valid && pnt.ready) || (smp.valid && smp.ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT)
        begin
            $display("watchdog: no progress, %0d samples outstanding", sample_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send(point_t p);
        point_q.insert(point_q.size(), p);
        tagged_known.insert(tagged_known.size(), p);
    endtask

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        @(posedge clk);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1;
        do @(posedge clk); while (!pready);
        if (addr == ADDR_MIN_WEIGHT) weight_floor = data[MWS_W-1:0];
        psel <= 0;
        penable <= 0;
    endtask

    // hold until every point is taken and every sample has come back
    task automatic drain();
        wait (point_q.size() == 0);
        @(posedge clk);
        while (pnt.valid || sample_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [COORD_W-1:0] rnd_coord();
        return COORD_W'($urandom);
    endfunction

    // one random stroke of random shape
    task automatic random_stroke(int npts, bit lng);
        point_t p;
        int     mode;
        logic signed [COORD_W-1:0] cx, cy;
        mode = $urandom_range(3);
        cx = rnd_coord();
        cy = rnd_coord();
        for (int i = 0; i < npts; i++)
        begin
            p = '{cx, cy, i == npts - 1, 0, 0, 0, 0};
            if (mode == 0 && !lng)
            begin
                p.x = rnd_coord();
                p.y = rnd_coord();
            end
            else if (mode != 3 || $urandom_range(1))
            begin
                p.x = cx + COORD_W'($signed($urandom_range(0, 200)) - 100);
                p.y = cy + COORD_W'($signed($urandom_range(0, 200)) - 100);
            end
            cx = p.x;
            cy = p.y;
            p.tgt = lng ? TGT_W'(MAX_OUT_POINTS) :
                    ($urandom_range(3) == 0) ? TGT_W'($urandom) : TGT_W'($urandom_range(1, 20));
            if (!p.last) p.tgt = TGT_W'($urandom);
            send(p);
        end
    endtask

    // directed table: single points, extremes, zero length, small targets
    point_t table_rows [] = '{
        '{16'sd0,      16'sd0,      1, 7'd1,   1, 16'sd0,      16'sd0},
        '{16'sd32767,  -16'sd32768, 1, 7'd5,   1, 16'sd32767,  -16'sd32768},
        '{-16'sd32768, 16'sd32767,  1, 7'd0,   1, -16'sd32768, 16'sd32767},
        '{16'sd100,    -16'sd7,     1, 7'd127, 1, 16'sd100,    -16'sd7},
        '{-16'sd32768, -16'sd32768, 0, 7'd0,   0, 0, 0},
        '{16'sd32767,  16'sd32767,  1, 7'd64,  0, 0, 0},
        '{16'sd10,     16'sd20,     0, 7'd0,   0, 0, 0},
        '{-16'sd300,   16'sd4000,   1, 7'd1,   0, 0, 0},
        '{16'sd5,      16'sd5,      0, 7'd0,   0, 0, 0},
        '{16'sd5,      16'sd5,      0, 7'd0,   0, 0, 0},
        '{16'sd5,      16'sd5,      1, 7'd10,  1, 16'sd5,      16'sd5},
        '{16'sd16,     16'sd0,      0, 7'd0,   0, 0, 0},
        '{16'sd17,     16'sd0,      0, 7'd0,   0, 0, 0},
        '{16'sd17,     16'sd1,      0, 7'd0,   0, 0, 0},
        '{16'sd400,    -16'sd900,   1, 7'd9,   0, 0, 0},
        '{16'sd1,      16'sd2,      0, 7'd0,   0, 0, 0},
        '{16'sd3,      16'sd4,      1, 7'd2,   0, 0, 0},
        '{16'sd0,      16'sd0,      0, 7'd0,   0, 0, 0},
        '{16'sd0,      16'sd0,      0, 7'd0,   0, 0, 0},
        '{16'sd32,     16'sd32,     1, 7'd65,  0, 0, 0}
    };

    initial
    begin
        int n_items;
        logic [MWS_W-1:0] floors [4] = '{8'd0, 8'd255, 8'd40, 8'd0};
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        rst_n = 0;
        calm = 0;
        weight_floor = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;

        // directed part under the reset value of the register
        foreach (table_rows[i]) send(table_rows[i]);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            floors[2] = MWS_W'($urandom_range(1, 254));
            apb_write(ADDR_MIN_WEIGHT, PDATA_W'(floors[ph]) | 32'hFFFF_FF00);
            if (ph == 3) apb_write(ADDR_UNMAPPED, 32'h0000_00AA);
            calm = (ph == 1);
            if (ph == 2)
            begin
                // overfill the point store with one long stroke
                random_stroke(MAX_POINTS + 2, 1);
                hold_req = 1;
            end
            n_items = 0;
            while (n_items < 10)
            begin
                int npts;
                npts = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
                random_stroke(npts, 0);
                n_items += npts;
            end
            drain();
        end

        $display("covered %0d strokes and %0d resampled points over four register settings",
                 strokes_sent, samples_seen);
        $display("mismatches: %0d", errors);
        if (errors == 0 && sample_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/salr_pkg.sv
rtl/salr_pnt_if.sv
rtl/salr_smp_if.sv
rtl/stroke_arc_length_resampler.sv
test/stroke_arc_length_resampler_tb.sv
